// ===== rtl/set_assoc_aging_hash_table_core_assert.svh =====
// Assertion macros for the aging hash table core.
`ifndef SET_ASSOC_AGING_HASH_TABLE_CORE_ASSERT_SVH
`define SET_ASSOC_AGING_HASH_TABLE_CORE_ASSERT_SVH
// Implication checked on every clock, disabled in reset.
`define SAHT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SAHT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/saht_pkg.sv =====
// Shared constants for the aging hash table core.
package saht_pkg;
    // cluster count, a power of two, so the cluster index is the low key bits
    localparam int CLUSTER_COUNT = 1024;
    localparam logic [1:0] MODE_PROBE  = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_NEWGEN = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;
    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_EXACT = 2'd3;
    localparam int AGE_WEIGHT_SHIFT = 2;
    localparam logic [7:0] FIRST_GEN = 8'd1;
endpackage

// ===== rtl/set_assoc_aging_hash_table_core.sv =====
// Set-associative hash table with depth and age based replacement.
// Every request gives one result. A probe or store reads its cluster one way
// per cycle through a single memory read port and one shared compare unit;
// a store then writes the chosen way back. Entries carry a valid tag from a
// clear epoch, so a clear needs no walk of the table; after reset, and on
// every 255th clear, a sweep zeroes all CLUSTER_COUNT*WAYS entries, during
// which no request is accepted. The result waits in an output register; the
// next request is accepted once that result is taken, at the earliest in the
// same cycle.
module set_assoc_aging_hash_table_core #(
    parameter int WAYS          = 4,
    parameter int MOVE_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [63:0]        key,
    input  logic signed [7:0]  depth,
    input  logic signed [15:0] score,
    input  logic [1:0]         bound_kind,
    input  logic               move_present,
    input  logic [15:0]        move_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [7:0]  hit_depth,
    output logic signed [15:0] hit_score,
    output logic [1:0]         hit_bound,
    output logic               hit_has_move,
    output logic [15:0]        hit_move
);
    import saht_pkg::*;

    localparam int ENTRIES = CLUSTER_COUNT * WAYS;
    localparam int CB = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WCB = $clog2(WAYS + 1);
    localparam int MB = MOVE_BITS;
    // entry: epoch(8) key(64) depth(8) score(16) bound(2) gen(8) hm(1) move
    localparam int EW = 8 + 64 + 8 + 16 + 2 + 8 + 1 + MB;

    typedef struct packed {
        logic [7:0]        epoch;
        logic [63:0]       key;
        logic signed [7:0] depth;
        logic [15:0]       score;
        logic [1:0]        bound;
        logic [7:0]        gen;
        logic              mv_valid;
        logic [MB-1:0]     move;
    } entry_t;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [EW-1:0] mem [ENTRIES];
    entry_t rd_q;

    logic [2:0]   state_reg, state_next;
    logic [7:0]   gen_reg, epoch_reg;
    logic [1:0]   mode_reg;
    logic [63:0]  key_reg;
    logic signed [7:0] depth_reg;
    logic [15:0]  score_reg;
    logic [1:0]   bound_reg;
    logic         mp_reg;
    logic [MB-1:0] mv_reg;
    logic [CB-1:0] cl_reg;
    logic [WCB-1:0] issue_reg;   // ways issued
    logic [WCB-1:0] seen_reg;    // ways evaluated
    logic         found_reg;
    logic signed [7:0] bdep_reg;
    entry_t       bent_reg;
    logic         tfound_reg;    // store target found (key match or empty)
    logic [WB-1:0] tway_reg;
    entry_t       tent_reg;
    logic         tvalid_reg;
    logic signed [11:0] least_reg;
    logic [WB-1:0] lway_reg;
    entry_t       lent_reg;
    logic         lvalid_reg;
    logic [AB-1:0] sw_reg;
    logic         ov_reg, ov_next;

    // cluster index: low key bits
    logic [CB-1:0] cl_in;
    assign cl_in = key[CB-1:0];

    logic in_acc;
    assign in_stall = !(state_reg == ST_IDLE || state_reg == ST_DONE) ||
                      (ov_reg && out_stall);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = ov_reg;

    // read address
    logic [WB-1:0] rway;
    logic [AB-1:0] raddr;
    assign rway = WB'(issue_reg);
    assign raddr = AB'(cl_reg) * AB'(WAYS) + AB'(rway);

    // shared per-way evaluation
    logic         r_live;
    logic [WB-1:0] r_way;
    logic signed [11:0] keep;
    always_comb
    begin
        r_way = WB'(seen_reg);
        r_live = (rd_q.epoch == epoch_reg) && (rd_q.bound != BOUND_NONE);
        keep = 12'(rd_q.depth) - 12'(signed'({4'b0, 8'(gen_reg - rd_q.gen)}) <<<
               AGE_WEIGHT_SHIFT);
    end

    // write-back entry
    entry_t cur, wr_e;
    logic [WB-1:0] wr_way;
    always_comb
    begin
        wr_way = tfound_reg ? tway_reg : lway_reg;
        cur = tfound_reg ? tent_reg : lent_reg;
        if (!(tfound_reg ? tvalid_reg : lvalid_reg))
        begin
            cur.key = '0; cur.depth = '0; cur.score = '0; cur.bound = BOUND_NONE;
            cur.gen = '0; cur.mv_valid = 1'b0; cur.move = '0;
        end
        wr_e = cur;
        wr_e.epoch = epoch_reg;
        if (cur.key == key_reg && cur.bound != BOUND_NONE && depth_reg < cur.depth &&
            bound_reg != BOUND_EXACT)
        begin
            wr_e.gen = gen_reg;
            if (mp_reg && !cur.mv_valid)
            begin
                wr_e.move = mv_reg;
                wr_e.mv_valid = 1'b1;
            end
        end
        else
        begin
            wr_e.key = key_reg; wr_e.depth = depth_reg; wr_e.score = score_reg;
            wr_e.bound = bound_reg; wr_e.gen = gen_reg; wr_e.mv_valid = mp_reg;
            if (mp_reg)
                wr_e.move = mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q <= entry_t'(mem[raddr]);
        if (state_reg == ST_WRITE)
            mem[AB'(cl_reg) * AB'(WAYS) + AB'(wr_way)] <= EW'(wr_e);
        else if (state_reg == ST_SWEEP)
            mem[sw_reg] <= '0;
    end

    logic last_read;
    assign last_read = (seen_reg == WCB'(WAYS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
                if (in_acc)
                begin
                    if (mode == MODE_CLEAR && epoch_reg == 8'hFF)
                        state_next = ST_SWEEP;
                    else if (mode == MODE_PROBE || mode == MODE_STORE)
                        state_next = ST_READ;
                    else
                        state_next = ST_DONE;
                end
                else if (state_reg == ST_DONE && !(ov_reg && out_stall))
                    state_next = ST_IDLE;
            ST_READ:
                if (issue_reg != '0 && last_read)
                    state_next = (mode_reg == MODE_STORE) ? ST_WRITE : ST_DONE;
            ST_WRITE: state_next = ST_DONE;
            ST_SWEEP:
                if (sw_reg == AB'(ENTRIES - 1))
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg && out_stall;
        if (in_acc && (mode == MODE_NEWGEN || mode == MODE_CLEAR))
            ov_next = 1'b1;
        if (state_reg == ST_READ && issue_reg != '0 && last_read &&
            mode_reg == MODE_PROBE)
            ov_next = 1'b1;
        if (state_reg == ST_WRITE)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            gen_reg   <= FIRST_GEN;
            epoch_reg <= 8'd1;
            sw_reg    <= '0;
            ov_reg    <= 1'b0;
            issue_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            if (state_reg == ST_SWEEP)
                sw_reg <= sw_reg + 1'b1;
            if (in_acc)
            begin
                issue_reg <= '0;
                seen_reg  <= '0;
                if (mode == MODE_NEWGEN)
                    gen_reg <= (gen_reg == 8'hFF) ? 8'd1 : gen_reg + 8'd1;
                if (mode == MODE_CLEAR)
                begin
                    gen_reg <= FIRST_GEN;
                    if (epoch_reg == 8'hFF)
                    begin
                        epoch_reg <= 8'd1;
                        sw_reg <= '0;
                    end
                    else
                        epoch_reg <= epoch_reg + 8'd1;
                end
            end
            if (state_reg == ST_READ)
            begin
                if (issue_reg != WCB'(WAYS))
                    issue_reg <= issue_reg + 1'b1;
                if (issue_reg != '0)
                    seen_reg <= seen_reg + 1'b1;
            end
        end
    end

    // datapath registers and result
    logic pf;
    always_comb
        pf = r_live && rd_q.key == key_reg && (!found_reg || rd_q.depth > bdep_reg);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg <= mode; key_reg <= key; depth_reg <= depth;
            score_reg <= score; bound_reg <= bound_kind; mp_reg <= move_present;
            mv_reg <= MB'(move_code); cl_reg <= cl_in;
            found_reg <= 1'b0; tfound_reg <= 1'b0;
            hit <= 1'b0; hit_depth <= '0; hit_score <= '0; hit_bound <= '0;
            hit_has_move <= 1'b0; hit_move <= '0;
        end
        if (state_reg == ST_READ && issue_reg != '0)
        begin
            if (pf)
            begin
                found_reg <= 1'b1; bdep_reg <= rd_q.depth;
                bent_reg <= rd_q;
            end
            if (!tfound_reg && ((r_live ? rd_q.key : 64'd0) == key_reg || !r_live))
            begin
                tfound_reg <= 1'b1; tway_reg <= r_way; tent_reg <= rd_q;
                tvalid_reg <= r_live;
            end
            if (seen_reg == '0 || keep < least_reg)
            begin
                least_reg <= keep; lway_reg <= r_way; lent_reg <= rd_q;
                lvalid_reg <= r_live;
            end
            if (last_read && mode_reg == MODE_PROBE && (pf || found_reg))
            begin
                hit <= 1'b1;
                hit_depth <= pf ? rd_q.depth : bent_reg.depth;
                hit_score <= pf ? rd_q.score : bent_reg.score;
                hit_bound <= pf ? rd_q.bound : bent_reg.bound;
                hit_has_move <= pf ? rd_q.mv_valid : bent_reg.mv_valid;
                hit_move <= (pf ? rd_q.mv_valid : bent_reg.mv_valid) ?
                            16'(pf ? rd_q.move : bent_reg.move) : 16'd0;
            end
        end
    end
endmodule

// ===== rtl/saht_checker.sv =====
// Port-level assertions for the aging hash table core, with bind.
`include "set_assoc_aging_hash_table_core_assert.svh"
module saht_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic hit,
    input logic hit_has_move,
    input logic [15:0] hit_move
);
    `SAHT_ASSERT_NEXT(a_res_holds, clk, rst_n, out_valid && out_stall, out_valid)
    `SAHT_ASSERT_IMP(a_no_move_zero, clk, rst_n, out_valid && !hit_has_move, hit_move == 16'd0)
    `SAHT_ASSERT_IMP(a_move_needs_hit, clk, rst_n, out_valid && hit_has_move, hit)
    `SAHT_ASSERT_IMP(a_full_stalls, clk, rst_n, out_valid && out_stall, in_stall)
endmodule

bind set_assoc_aging_hash_table_core saht_checker u_chk (.*);

// ===== sim/tb_set_assoc_aging_hash_table_core.sv =====
// Testbench for the set-associative aging hash table core: self-checking, predictor based.
`timescale 1ns / 1ps

module tb_set_assoc_aging_hash_table_core;
    import saht_pkg::*;

    localparam int CLUSTERS = 1024;
    localparam int NWAYS = 4;
    localparam int ENTRIES = CLUSTERS * NWAYS;
    localparam int AGE_FACTOR = 4;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [7:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [7:0]         gen;
        logic               mv_valid;
        logic [15:0]        move;
    } slot_t;

    typedef struct packed {
        logic               hit;
        logic signed [7:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic               mv_valid;
        logic [15:0]        move;
    } lookup_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic [1:0]         bound_kind;
    logic               move_present;
    logic [15:0]        move_code;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic signed [7:0]  hit_depth;
    logic signed [15:0] hit_score;
    logic [1:0]         hit_bound;
    logic               hit_has_move;
    logic [15:0]        hit_move;

    // predictor state
    logic [63:0] mdl_key [ENTRIES];
    slot_t       mdl_slot [ENTRIES];
    logic [7:0]  mdl_gen;

    lookup_t     pending_lookups[$];
    int          fail_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          snk_hold = 0;
    int          quiet_cycles = 0;
    logic [53:0] key_hi_pool [8];

    set_assoc_aging_hash_table_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .key(key), .depth(depth), .score(score),
        .bound_kind(bound_kind), .move_present(move_present), .move_code(move_code),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_depth(hit_depth), .hit_score(hit_score), .hit_bound(hit_bound),
        .hit_has_move(hit_has_move), .hit_move(hit_move)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic wipe_model();
        for (int i = 0; i < ENTRIES; i++)
        begin
            mdl_key[i] = '0;
            mdl_slot[i] = '0;
        end
        mdl_gen = FIRST_GEN;
    endtask

    task automatic predict_request(input logic [1:0] m, input logic [63:0] k,
                                   input logic signed [7:0] d, input logic signed [15:0] s,
                                   input logic [1:0] b, input logic mp, input logic [15:0] mc);
        lookup_t res;
        int base;
        int best;
        int tgt;
        int least;
        int keep;
        logic [7:0] age;
        res = '0;
        base = int'(k[9:0]) * NWAYS;
        best = -1;
        tgt = -1;
        least = 0;
        if (m == MODE_PROBE)
        begin
            for (int w = 0; w < NWAYS; w++)
                if (mdl_key[base+w] == k && mdl_slot[base+w].bound != BOUND_NONE)
                    if (best < 0 || mdl_slot[base+w].depth > mdl_slot[base+best].depth)
                        best = w;
            if (best >= 0)
            begin
                res.hit = 1'b1;
                res.depth = mdl_slot[base+best].depth;
                res.score = mdl_slot[base+best].score;
                res.bound = mdl_slot[base+best].bound;
                res.mv_valid = mdl_slot[base+best].mv_valid;
                res.move = mdl_slot[base+best].mv_valid ? mdl_slot[base+best].move : 16'd0;
            end
        end
        else if (m == MODE_STORE)
        begin
            for (int w = 0; w < NWAYS; w++)
                if (tgt < 0 && (mdl_key[base+w] == k || mdl_slot[base+w].bound == BOUND_NONE))
                    tgt = w;
            if (tgt < 0)
                for (int w = 0; w < NWAYS; w++)
                begin
                    age = mdl_gen - mdl_slot[base+w].gen;
                    keep = int'(mdl_slot[base+w].depth) - AGE_FACTOR * int'(age);
                    if (tgt < 0 || keep < least)
                    begin
                        least = keep;
                        tgt = w;
                    end
                end
            if (mdl_key[base+tgt] == k && mdl_slot[base+tgt].bound != BOUND_NONE &&
                d < mdl_slot[base+tgt].depth && b != BOUND_EXACT)
            begin
                // shallower non-exact store on the same key: refresh only
                mdl_slot[base+tgt].gen = mdl_gen;
                if (mp && !mdl_slot[base+tgt].mv_valid)
                begin
                    mdl_slot[base+tgt].move = mc;
                    mdl_slot[base+tgt].mv_valid = 1'b1;
                end
            end
            else
            begin
                mdl_key[base+tgt] = k;
                mdl_slot[base+tgt].depth = d;
                mdl_slot[base+tgt].score = s;
                mdl_slot[base+tgt].bound = b;
                mdl_slot[base+tgt].gen = mdl_gen;
                mdl_slot[base+tgt].mv_valid = mp;
                if (mp)
                    mdl_slot[base+tgt].move = mc;
            end
        end
        else if (m == MODE_NEWGEN)
        begin
            mdl_gen = mdl_gen + 8'd1;
            if (mdl_gen == 8'd0)
                mdl_gen = FIRST_GEN;
        end
        else
            wipe_model();
        pending_lookups.push_back(res);
    endtask

    task automatic send_request(input logic [1:0] m, input logic [63:0] k,
                                input logic signed [7:0] d, input logic signed [15:0] s,
                                input logic [1:0] b, input logic mp, input logic [15:0] mc);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        key <= k;
        depth <= d;
        score <= s;
        bound_kind <= b;
        move_present <= mp;
        move_code <= mc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(m, k, d, s, b, mp, mc);
    endtask

    task automatic send_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // most keys fall in four clusters with eight upper patterns so hits and evictions happen
    function automatic logic [63:0] pick_key();
        logic [9:0] cl;
        if ($urandom_range(0, 19) == 0)
            return {$urandom, $urandom};
        cl = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3) * 257);
        return {key_hi_pool[$urandom_range(0, 7)], cl};
    endfunction

    task automatic send_random_store(input logic [63:0] k);
        send_request(MODE_STORE, k, 8'($urandom), 16'($urandom),
                     2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        logic [63:0] k1;
        logic [63:0] k2;
        k1 = {54'h2a_5555_aaaa_1234, 10'd5};
        k2 = {54'h15_aaaa_5555_4321, 10'd5};
        send_request(MODE_PROBE, 64'd0, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_STORE, 64'd0, 8'sd127, 16'sh7fff, BOUND_NONE, 1'b1, 16'hffff);
        send_request(MODE_PROBE, 64'd0, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_STORE, '1, -8'sd128, -16'sd32768, BOUND_EXACT, 1'b1, 16'hffff);
        send_request(MODE_PROBE, '1, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_STORE, k1, 8'sd10, 16'sd100, BOUND_LOWER, 1'b0, 16'h1234);
        send_request(MODE_PROBE, k1, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        // shallower upper bound: refresh, move gets added
        send_request(MODE_STORE, k1, 8'sd3, 16'sd7, BOUND_UPPER, 1'b1, 16'hbeef);
        send_request(MODE_PROBE, k1, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        // shallower but exact: overwrite
        send_request(MODE_STORE, k1, 8'sd2, -16'sd5, BOUND_EXACT, 1'b0, 16'h0);
        send_request(MODE_PROBE, k1, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_NEWGEN, 64'd0, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        // fill cluster 5 and evict
        send_request(MODE_STORE, k2, 8'sd20, 16'sd1, BOUND_LOWER, 1'b1, 16'h0001);
        send_request(MODE_STORE, k2 ^ 64'h400, 8'sd30, 16'sd2, BOUND_UPPER, 1'b1, 16'h0002);
        send_request(MODE_STORE, k2 ^ 64'h800, 8'sd40, 16'sd3, BOUND_EXACT, 1'b0, 16'h0003);
        send_request(MODE_STORE, k2 ^ 64'hc00, 8'sd5, 16'sd4, BOUND_LOWER, 1'b1, 16'h0004);
        send_request(MODE_PROBE, k1, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_PROBE, k2, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_CLEAR, 64'd0, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        send_request(MODE_PROBE, k2, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
    endtask

    task automatic test_random(input int count, input int src_pct, input int snk_pct);
        logic [63:0] k;
        int r;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < count; i++)
        begin
            k = pick_key();
            r = $urandom_range(0, 99);
            if (r < 45)
                send_request(MODE_PROBE, k, 8'($urandom), 16'($urandom),
                             2'($urandom), 1'($urandom), 16'($urandom));
            else if (r < 92)
                send_random_store(k);
            else if (r < 98)
                send_request(MODE_NEWGEN, k, 8'($urandom), 16'($urandom),
                             2'($urandom), 1'($urandom), 16'($urandom));
            else
                send_request(MODE_CLEAR, k, 8'($urandom), 16'($urandom),
                             2'($urandom), 1'($urandom), 16'($urandom));
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    // generation runs past 255 so ages wrap and zero is skipped
    task automatic test_generation_wrap();
        for (int i = 0; i < 260; i++)
        begin
            if (i % 65 == 0)
                send_random_store(pick_key());
            send_request(MODE_NEWGEN, 64'd0, 8'd0, 16'd0, BOUND_NONE, 1'b0, 16'd0);
        end
        for (int i = 0; i < 12; i++)
            send_random_store({key_hi_pool[i % 8], 10'($urandom_range(0, 1) * 257)});
    endtask

    task automatic test_backpressure();
        snk_hold = 200;
        for (int i = 0; i < 20; i++)
            send_random_store(pick_key());
    endtask

    // result side: random stall, long hold when asked, compare against oldest prediction
    always @(posedge clk)
    begin
        lookup_t exp_res;
        if (out_valid && !out_stall && rst_n)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                exp_res = pending_lookups.pop_front();
                if (hit !== exp_res.hit)
                begin
                    $error("hit exp %0d got %0d", exp_res.hit, hit);
                    fail_count++;
                end
                if (hit_depth !== exp_res.depth)
                begin
                    $error("hit_depth exp %0d got %0d", exp_res.depth, hit_depth);
                    fail_count++;
                end
                if (hit_score !== exp_res.score)
                begin
                    $error("hit_score exp %0d got %0d", exp_res.score, hit_score);
                    fail_count++;
                end
                if (hit_bound !== exp_res.bound)
                begin
                    $error("hit_bound exp %0d got %0d", exp_res.bound, hit_bound);
                    fail_count++;
                end
                if (hit_has_move !== exp_res.mv_valid)
                begin
                    $error("hit_has_move exp %0d got %0d", exp_res.mv_valid, hit_has_move);
                    fail_count++;
                end
                if (hit_move !== exp_res.move)
                begin
                    $error("hit_move exp %h got %h", exp_res.move, hit_move);
                    fail_count++;
                end
            end
        end
        if (snk_hold > 0)
        begin
            snk_hold <= snk_hold - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (snk_stall_pct > 0 && $urandom_range(0, 99) < snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || snk_hold > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb_set_assoc_aging_hash_table_core: FAIL");
            $finish;
        end
    end

    initial
    begin
        int drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        mode = MODE_PROBE;
        key = '0;
        depth = '0;
        score = '0;
        bound_kind = BOUND_NONE;
        move_present = 1'b0;
        move_code = '0;
        for (int i = 0; i < 8; i++)
            key_hi_pool[i] = 54'({$urandom, $urandom});
        wipe_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(30, 0, 0);
        test_random(30, 66, 0);
        test_random(30, 0, 66);
        test_random(30, 6, 6);
        test_backpressure();
        test_generation_wrap();
        test_random(10, 0, 0);
        send_idle();

        drain = 0;
        while (pending_lookups.size() != 0 && drain < IDLE_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_lookups.size() == 0)
            $display("tb_set_assoc_aging_hash_table_core: PASS");
        else
            $display("tb_set_assoc_aging_hash_table_core: FAIL");
        $finish;
    end
endmodule

// ===== set_assoc_aging_hash_table_core.f =====
+incdir+rtl
rtl/saht_pkg.sv
rtl/set_assoc_aging_hash_table_core.sv
rtl/saht_checker.sv
sim/tb_set_assoc_aging_hash_table_core.sv
